// ===== rtl/core/tkgd_pkg.sv =====
// Package for the touch and key gamepad decoder core.
// Holds sizes, item and register codes, the button rectangle table and the key map.
// Used by tkgd_div and the top-level core under rtl/core; tkgd_ram does not import it.
`timescale 1ns / 1ps

package tkgd_pkg;

  localparam int POINTER_SLOTS = 16;
  localparam int COORD_BITS    = 12;
  localparam int PTR_IDX_W     = $clog2(POINTER_SLOTS);
  localparam int BTN_W         = 10;
  localparam int KIND_W        = 3;
  localparam int ID_W          = 8;
  localparam int KEY_W         = 8;
  localparam int CFG_IDX_W     = 1;

  // Scaled grid is 240x160; both factors stay below 256, so eight extra bits hold the product
  localparam int GRID_W        = 240;
  localparam int GRID_H        = 160;
  localparam int DIVIDEND_W    = COORD_BITS + 8;
  localparam int DIV_CNT_W     = $clog2(DIVIDEND_W);

  localparam logic [BTN_W-1:0] ALL_RELEASED = {BTN_W{1'b1}};

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_TOUCH_DOWN = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TOUCH_MOVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TOUCH_UP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_KEY_DOWN   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_KEY_UP     = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [COORD_BITS-1:0] SCREEN_WIDTH_RST  = COORD_BITS'(240);
  localparam logic [COORD_BITS-1:0] SCREEN_HEIGHT_RST = COORD_BITS'(160);

  // Button masks, bit 0 upward: A, B, Select, Start, Right, Left, Up, Down, R, L
  localparam logic [BTN_W-1:0] BTN_A      = 10'h001;
  localparam logic [BTN_W-1:0] BTN_B      = 10'h002;
  localparam logic [BTN_W-1:0] BTN_SELECT = 10'h004;
  localparam logic [BTN_W-1:0] BTN_START  = 10'h008;
  localparam logic [BTN_W-1:0] BTN_RIGHT  = 10'h010;
  localparam logic [BTN_W-1:0] BTN_LEFT   = 10'h020;
  localparam logic [BTN_W-1:0] BTN_UP     = 10'h040;
  localparam logic [BTN_W-1:0] BTN_DOWN   = 10'h080;
  localparam logic [BTN_W-1:0] BTN_R      = 10'h100;
  localparam logic [BTN_W-1:0] BTN_L      = 10'h200;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_UP_ARROW    = 8'd19;
  localparam logic [KEY_W-1:0] KEY_DOWN_ARROW  = 8'd20;
  localparam logic [KEY_W-1:0] KEY_LEFT_ARROW  = 8'd21;
  localparam logic [KEY_W-1:0] KEY_RIGHT_ARROW = 8'd22;
  localparam logic [KEY_W-1:0] KEY_A_0         = 8'd29;
  localparam logic [KEY_W-1:0] KEY_A_1         = 8'd54;
  localparam logic [KEY_W-1:0] KEY_B_0         = 8'd30;
  localparam logic [KEY_W-1:0] KEY_B_1         = 8'd31;
  localparam logic [KEY_W-1:0] KEY_START_0     = 8'd62;
  localparam logic [KEY_W-1:0] KEY_START_1     = 8'd66;
  localparam logic [KEY_W-1:0] KEY_SELECT_0    = 8'd4;
  localparam logic [KEY_W-1:0] KEY_SELECT_1    = 8'd59;
  localparam logic [KEY_W-1:0] KEY_L           = 8'd45;
  localparam logic [KEY_W-1:0] KEY_R           = 8'd51;

  // Half-open rectangles on the 240x160 grid: left <= x < right, top <= y < bottom
  localparam int NUM_RECTS = 11;
  localparam logic [8:0] RECT_LEFT   [NUM_RECTS] =
    '{9'd184, 9'd124, 9'd184, 9'd8,   9'd60,  9'd120, 9'd60,  9'd32, 9'd88, 9'd184, 9'd232};
  localparam logic [8:0] RECT_RIGHT  [NUM_RECTS] =
    '{9'd232, 9'd172, 9'd232, 9'd56,  9'd108, 9'd168, 9'd108, 9'd80, 9'd136, 9'd232, 9'd256};
  localparam logic [8:0] RECT_TOP    [NUM_RECTS] =
    '{9'd104, 9'd104, 9'd44,  9'd104, 9'd104, 9'd104, 9'd44,  9'd8,  9'd8,  9'd16,  9'd128};
  localparam logic [8:0] RECT_BOTTOM [NUM_RECTS] =
    '{9'd152, 9'd152, 9'd92,  9'd152, 9'd152, 9'd152, 9'd92,  9'd56, 9'd56, 9'd64,  9'd152};
  localparam logic [BTN_W-1:0] RECT_BTN [NUM_RECTS] =
    '{BTN_A, BTN_B, BTN_B, BTN_LEFT, BTN_DOWN, BTN_RIGHT, BTN_UP, BTN_START, BTN_SELECT,
      BTN_L, BTN_R};

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Mask of every button whose rectangle holds the scaled point
  function automatic logic [BTN_W-1:0] rect_hits(input logic [DIVIDEND_W-1:0] tx,
                                                 input logic [DIVIDEND_W-1:0] ty);
    logic [BTN_W-1:0] m;
    m = '0;
    for (int i = 0; i < NUM_RECTS; i++) begin
      if (tx >= DIVIDEND_W'(RECT_LEFT[i]) && tx < DIVIDEND_W'(RECT_RIGHT[i]) &&
          ty >= DIVIDEND_W'(RECT_TOP[i])  && ty < DIVIDEND_W'(RECT_BOTTOM[i])) begin
        m = m | RECT_BTN[i];
      end
    end
    return m;
  endfunction

  function automatic logic [BTN_W-1:0] key_mask(input logic [KEY_W-1:0] code);
    logic [BTN_W-1:0] m;
    case (code)
      KEY_UP_ARROW:                m = BTN_UP;
      KEY_DOWN_ARROW:              m = BTN_DOWN;
      KEY_LEFT_ARROW:              m = BTN_LEFT;
      KEY_RIGHT_ARROW:             m = BTN_RIGHT;
      KEY_A_0, KEY_A_1:            m = BTN_A;
      KEY_B_0, KEY_B_1:            m = BTN_B;
      KEY_START_0, KEY_START_1:    m = BTN_START;
      KEY_SELECT_0, KEY_SELECT_1:  m = BTN_SELECT;
      KEY_L:                       m = BTN_L;
      KEY_R:                       m = BTN_R;
      default:                     m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/tkgd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module tkgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/tkgd_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the x and y scaling.
// Depends on tkgd_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps

module tkgd_div
  import tkgd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [COORD_BITS-1:0] divisor,
  output div_status_t           status,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic [COORD_BITS-1:0] rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [COORD_BITS-1:0] dvs_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  busy_r, done_r;
  logic [COORD_BITS:0]   rem_sh, diff;
  logic                  ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIVIDEND_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    diff    = rem_sh - {1'b0, dvs_r};
    rem_nxt = ge ? diff[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
    quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

// ===== rtl/core/touch_and_key_gamepad_decoder_core.sv =====
// Touch and key gamepad decoder: top level with the sequencer, pointer table and button word.
// Key and unknown items give their result in the cycle after the input beat. A touch item
// walks all 16 pointer slots unless the screen width or height is zero; an active slot takes
// the table read plus an x and a y divide on the shared divider, an inactive one is only checked.
// One item at a time; in_ready is low until the result beat is taken.
// Reset (rst_n low, synchronous): all pointers inactive, word all released, screen 240x160.
`timescale 1ns / 1ps

module touch_and_key_gamepad_decoder_core
  import tkgd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [ID_W-1:0]       in_pointer_id,
  input  logic [COORD_BITS-1:0] in_x_coord,
  input  logic [COORD_BITS-1:0] in_y_coord,
  input  logic [KEY_W-1:0]      in_key_code,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BTN_W-1:0]      out_button_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_wdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_LOADX = 3'd2;
  localparam logic [2:0] ST_DIVX  = 3'd3;
  localparam logic [2:0] ST_DIVY  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam logic [PTR_IDX_W-1:0] LAST_SLOT = PTR_IDX_W'(POINTER_SLOTS - 1);

  logic [2:0]                  state_r, state_nxt;
  logic [PTR_IDX_W-1:0]        slot_r, slot_nxt;
  logic [POINTER_SLOTS-1:0]    active_r, active_nxt;
  logic [BTN_W-1:0]            buttons_r, buttons_nxt;
  logic [COORD_BITS-1:0]       width_r, height_r;
  logic [COORD_BITS-1:0]       y_r, y_nxt;
  logic [DIVIDEND_W-1:0]       tx_r, tx_nxt;

  logic                        in_fire, slot_ok;
  logic [PTR_IDX_W-1:0]        in_slot;
  logic                        ram_we, ram_re;
  logic [2*COORD_BITS-1:0]     ram_rdata;
  logic                        div_start;
  logic [DIVIDEND_W-1:0]       div_dividend, div_quo;
  logic [COORD_BITS-1:0]       div_divisor;
  div_status_t                 div_st;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_button_word = buttons_r;
  assign cfg_ready = 1'b1;

  assign slot_ok = in_pointer_id < ID_W'(POINTER_SLOTS);
  assign in_slot = in_pointer_id[PTR_IDX_W-1:0];
  assign ram_we  = in_fire && slot_ok &&
                   (in_kind == KIND_TOUCH_DOWN || in_kind == KIND_TOUCH_MOVE);
  assign ram_re  = (state_r == ST_SCAN) && active_r[slot_r];

  tkgd_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (POINTER_SLOTS)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_slot),
    .wdata ({in_y_coord, in_x_coord}),
    .re    (ram_re),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  tkgd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_st),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt    = state_r;
    slot_nxt     = slot_r;
    active_nxt   = active_r;
    buttons_nxt  = buttons_r;
    y_nxt        = y_r;
    tx_nxt       = tx_r;
    div_start    = 1'b0;
    div_dividend = DIVIDEND_W'(ram_rdata[COORD_BITS-1:0]) * DIVIDEND_W'(GRID_W);
    div_divisor  = width_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_OUT;
          slot_nxt  = '0;
          unique case (in_kind)
            KIND_TOUCH_DOWN, KIND_TOUCH_MOVE, KIND_TOUCH_UP: begin
              if (slot_ok && in_kind == KIND_TOUCH_DOWN) active_nxt[in_slot] = 1'b1;
              if (slot_ok && in_kind == KIND_TOUCH_UP)   active_nxt[in_slot] = 1'b0;
              // Rebuild from scratch: key presses are dropped
              buttons_nxt = ALL_RELEASED;
              if (width_r != '0 && height_r != '0) state_nxt = ST_SCAN;
            end
            KIND_KEY_DOWN: buttons_nxt = buttons_r & ~key_mask(in_key_code);
            KIND_KEY_UP:   buttons_nxt = buttons_r | key_mask(in_key_code);
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (active_r[slot_r]) begin
          state_nxt = ST_LOADX;
        end else if (slot_r == LAST_SLOT) begin
          state_nxt = ST_OUT;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      ST_LOADX: begin
        // Read data is here: hold y, start the x divide
        y_nxt     = ram_rdata[2*COORD_BITS-1:COORD_BITS];
        div_start = 1'b1;
        state_nxt = ST_DIVX;
      end
      ST_DIVX: begin
        div_dividend = DIVIDEND_W'(y_r) * DIVIDEND_W'(GRID_H);
        div_divisor  = height_r;
        if (div_st.done) begin
          tx_nxt    = div_quo;
          div_start = 1'b1;
          state_nxt = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_st.done) begin
          buttons_nxt = buttons_r & ~rect_hits(tx_r, div_quo);
          if (slot_r == LAST_SLOT) begin
            state_nxt = ST_OUT;
          end else begin
            slot_nxt  = slot_r + 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      slot_r    <= '0;
      active_r  <= '0;
      buttons_r <= ALL_RELEASED;
      width_r   <= SCREEN_WIDTH_RST;
      height_r  <= SCREEN_HEIGHT_RST;
    end else begin
      state_r   <= state_nxt;
      slot_r    <= slot_nxt;
      active_r  <= active_nxt;
      buttons_r <= buttons_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
          REG_SCREEN_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    y_r  <= y_nxt;
    tx_r <= tx_nxt;
  end

  // The input and result sides never overlap
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // The divider is only started when it is free
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  // A taken result returns the block to idle
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready)
    else $error("block not idle after result beat");

  // The x divide is never started without a table read just before it
  a_read_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOADX) |-> $past(ram_re))
    else $error("x divide started without a pointer read");

endmodule
